### rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the threshold run segmenter
// widths, register indexes and the segment job passed from front to back
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int POS_WIDTH    = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COUNT_WIDTH  = 32;
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int CSR_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int GUARD_WIDTH  = 16;
   localparam int SEG_WIDTH    = 32;
   localparam int AVG_WIDTH    = 16;
   localparam int NUM_WIDTH    = 32;
   localparam int TOTAL_WIDTH  = 32;
   localparam int MIN_WIDTH    = 32;
   localparam int THR_IN_WIDTH = 16;

   // signed working width for guard and clamp arithmetic
   localparam int EXT_WIDTH = ((POS_WIDTH > TOTAL_WIDTH) ? POS_WIDTH : TOTAL_WIDTH) + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS  = SUM_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_WIDTH-1:0] REG_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_SIZE    = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BEGIN_GUARD = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_END_PAD     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_TOTAL_SIZE  = 3'd4;

   typedef logic [POS_WIDTH-1:0]          pos_type;
   typedef logic [SAMPLE_WIDTH-1:0]       smp_type;
   typedef logic [SUM_WIDTH-1:0]          sum_type;
   typedef logic [COUNT_WIDTH-1:0]        cnt_type;
   typedef logic [NUM_WIDTH-1:0]          num_type;
   typedef logic [SEG_WIDTH-1:0]          seg_type;
   typedef logic [AVG_WIDTH-1:0]          avg_type;
   typedef logic signed [GUARD_WIDTH-1:0] guard_type;
   typedef logic [TOTAL_WIDTH-1:0]        total_type;
   typedef logic [MIN_WIDTH-1:0]          min_type;
   typedef logic signed [EXT_WIDTH-1:0]   ext_type;
   typedef logic [EXT_WIDTH-1:0]          cmp_type;
   typedef logic [STEP_WIDTH-1:0]         step_type;

   // one qualified run, waiting for guard clamps and the average
   typedef struct packed {
      pos_type first;
      pos_type last;
      sum_type sum;
      cnt_type count;
      num_type number;
   } seg_job_type;

endpackage

### rtl/trs_queue.sv
// ----------------------------------------------------------------------------
// trs_queue: short job queue between front and back
// register based, push while not full and pop while not empty, one each per cycle
// ----------------------------------------------------------------------------
module trs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  trs_pkg::seg_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output trs_pkg::seg_job_type pop_data,
   output logic                 empty
);

   trs_pkg::seg_job_type                 slot_ff [trs_pkg::QUEUE_DEPTH];
   logic [trs_pkg::QPTR_WIDTH-1:0]       wr_ptr_ff;
   logic [trs_pkg::QPTR_WIDTH-1:0]       rd_ptr_ff;
   logic [trs_pkg::QCNT_WIDTH-1:0]       fill_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign full     = (fill_ff == trs_pkg::QCNT_WIDTH'(trs_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push & ~do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop & ~do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/trs_front.sv
// ----------------------------------------------------------------------------
// trs_front: sample classifier and run tracker
// extends runs, closes them and queues qualifying segments
// ----------------------------------------------------------------------------
module trs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_op,
   input  trs_pkg::smp_type     req_sample,
   input  trs_pkg::pos_type     req_position,
   input  trs_pkg::smp_type     threshold,
   input  trs_pkg::min_type     min_size,
   input  logic                 q_full,
   output logic                 q_push,
   output trs_pkg::seg_job_type q_data
);

   logic                           in_run_ff,  in_run_in;
   trs_pkg::pos_type               first_ff,   first_in;
   trs_pkg::pos_type               last_ff,    last_in;
   trs_pkg::sum_type               sum_ff,     sum_in;
   trs_pkg::cnt_type               count_ff,   count_in;
   trs_pkg::num_type               emitted_ff, emitted_in;

   logic                           accept;
   logic                           over;
   logic                           close_run;
   logic                           extend_run;
   logic                           qualify;
   trs_pkg::pos_type               run_span;
   logic [trs_pkg::SUM_WIDTH:0]    sum_wide;

   assign req_full   = q_full;
   assign accept     = req_push & ~q_full;
   assign over       = (req_sample > threshold);
   assign close_run  = accept & (req_op | over);
   assign extend_run = accept & ~req_op & ~over;

   // distance wraps when positions go backwards
   assign run_span = last_ff - first_ff;
   assign qualify  = (first_ff != last_ff) &&
                     (trs_pkg::cmp_type'(run_span) >= trs_pkg::cmp_type'(min_size));

   assign sum_wide = {1'b0, sum_ff} + (trs_pkg::SUM_WIDTH + 1)'(req_sample);

   assign q_push        = close_run & qualify;
   assign q_data.first  = first_ff;
   assign q_data.last   = last_ff;
   assign q_data.sum    = sum_ff;
   assign q_data.count  = count_ff;
   assign q_data.number = emitted_ff + 1'b1;

   always_comb begin
      in_run_in  = in_run_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      emitted_in = emitted_ff;
      if (close_run) begin
         in_run_in = 1'b0;
         first_in  = '0;
         last_in   = '0;
         sum_in    = '0;
         count_in  = '0;
         if (qualify) begin
            emitted_in = emitted_ff + 1'b1;
         end
      end else if (extend_run) begin
         in_run_in = 1'b1;
         if (!in_run_ff) begin
            first_in = req_position;
         end
         last_in  = req_position;
         // saturating accumulation
         sum_in   = sum_wide[trs_pkg::SUM_WIDTH] ? '1 : sum_wide[trs_pkg::SUM_WIDTH-1:0];
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff  <= 1'b0;
         first_ff   <= '0;
         last_ff    <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         emitted_ff <= '0;
      end else begin
         in_run_ff  <= in_run_in;
         first_ff   <= first_in;
         last_ff    <= last_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

### rtl/trs_back.sv
// ----------------------------------------------------------------------------
// trs_back: segment finisher
// guard clamps, bit-serial average division and the result register
// ----------------------------------------------------------------------------
module trs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  trs_pkg::guard_type   begin_guard,
   input  trs_pkg::guard_type   end_pad,
   input  trs_pkg::total_type   total_size,
   input  logic                 q_empty,
   input  trs_pkg::seg_job_type q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output trs_pkg::seg_type     rsp_seg_begin,
   output trs_pkg::seg_type     rsp_seg_end,
   output trs_pkg::avg_type     rsp_seg_average,
   output trs_pkg::num_type     rsp_seg_number
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic                               state_ff, state_in;
   trs_pkg::step_type                  step_ff, step_in;
   trs_pkg::sum_type                   quo_ff, quo_in;
   logic [trs_pkg::COUNT_WIDTH:0]      rem_ff, rem_in;
   trs_pkg::cnt_type                   divisor_ff;
   logic                               zero_div_ff;
   trs_pkg::pos_type                   begin_ff;
   trs_pkg::pos_type                   end_ff;
   trs_pkg::num_type                   number_ff;

   logic                               out_valid_ff, out_valid_in;
   trs_pkg::seg_type                   out_begin_ff;
   trs_pkg::seg_type                   out_end_ff;
   trs_pkg::avg_type                   out_avg_ff;
   trs_pkg::num_type                   out_number_ff;

   trs_pkg::ext_type                   pos_max;
   trs_pkg::ext_type                   b_raw;
   trs_pkg::ext_type                   b_clamp;
   trs_pkg::ext_type                   e_raw;
   trs_pkg::ext_type                   e_hi;
   trs_pkg::ext_type                   e_clamp;
   trs_pkg::ext_type                   total_ext;

   logic [trs_pkg::COUNT_WIDTH:0]      rem_shift;
   logic                               q_bit;
   trs_pkg::sum_type                   quo_final;
   trs_pkg::smp_type                   avg_sat;
   logic                               last_step;
   logic                               out_free;
   logic                               finish;

   // guard clamps on the queue head
   assign pos_max   = trs_pkg::ext_type'(trs_pkg::pos_type'('1));
   assign total_ext = trs_pkg::ext_type'(total_size);
   assign b_raw     = trs_pkg::ext_type'(q_data.first) - trs_pkg::ext_type'(begin_guard);
   assign e_raw     = trs_pkg::ext_type'(q_data.last) + trs_pkg::ext_type'(end_pad);
   assign e_hi      = (total_ext > pos_max) ? pos_max : total_ext;

   always_comb begin
      if (b_raw < 0) begin
         b_clamp = '0;
      end else if (b_raw > pos_max) begin
         b_clamp = pos_max;
      end else begin
         b_clamp = b_raw;
      end
      if (e_raw > e_hi) begin
         e_clamp = e_hi;
      end else if (e_raw < 0) begin
         e_clamp = '0;
      end else begin
         e_clamp = e_raw;
      end
   end

   // one restoring division step
   assign rem_shift = {rem_ff[trs_pkg::COUNT_WIDTH-1:0], quo_ff[trs_pkg::SUM_WIDTH-1]};
   assign q_bit     = (rem_shift >= {1'b0, divisor_ff});
   assign quo_final = {quo_ff[trs_pkg::SUM_WIDTH-2:0], q_bit};

   always_comb begin
      if (zero_div_ff) begin
         avg_sat = '0;
      end else if (quo_final > trs_pkg::sum_type'(trs_pkg::smp_type'('1))) begin
         avg_sat = '1;
      end else begin
         avg_sat = quo_final[trs_pkg::SAMPLE_WIDTH-1:0];
      end
   end

   assign last_step = (step_ff == trs_pkg::step_type'(trs_pkg::DIV_STEPS - 1));
   assign out_free  = ~out_valid_ff | rsp_pop;
   assign finish    = (state_ff == ST_DIV) & last_step & out_free;
   assign q_pop     = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_DIV;
               step_in  = '0;
               quo_in   = q_data.sum;
               rem_in   = '0;
            end
         end
         ST_DIV: begin
            // hold on the last step until the result register frees up
            if (!last_step || out_free) begin
               step_in = step_ff + 1'b1;
               quo_in  = quo_final;
               rem_in  = q_bit ? (rem_shift - {1'b0, divisor_ff}) : rem_shift;
               if (last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      if (q_pop) begin
         divisor_ff  <= q_data.count;
         zero_div_ff <= (q_data.count == '0);
         begin_ff    <= b_clamp[trs_pkg::POS_WIDTH-1:0];
         end_ff      <= e_clamp[trs_pkg::POS_WIDTH-1:0];
         number_ff   <= q_data.number;
      end
      if (finish) begin
         out_begin_ff  <= trs_pkg::seg_type'(begin_ff);
         out_end_ff    <= trs_pkg::seg_type'(end_ff);
         out_avg_ff    <= trs_pkg::avg_type'(avg_sat);
         out_number_ff <= number_ff;
      end
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_seg_begin   = out_begin_ff;
   assign rsp_seg_end     = out_end_ff;
   assign rsp_seg_average = out_avg_ff;
   assign rsp_seg_number  = out_number_ff;

endmodule

### rtl/threshold_run_segmenter_unit.sv
// ----------------------------------------------------------------------------
// threshold_run_segmenter_unit: top level of the threshold run segmenter
// groups low samples into runs and reports guarded segments with their mean
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  req_     | in        | push / full           | op, sample, position
//  rsp_     | out       | empty / pop           | seg_begin, seg_end, seg_average,
//           |           |                       | seg_number
//  csr_     | in        | we (no wait)          | index, wdata
//
//  a sample beat is taken every cycle while the job queue has room
//  per segment the back end loads the job, then divides one quotient bit per cycle
//  (last bit held until the result register frees); it takes no job while busy
//  a four-deep job queue absorbs bursts of closing runs; full rises when it fills
//  synchronous reset clears the run state, the queue and the result register
//  at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module threshold_run_segmenter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample beats
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_op,
   input  logic [trs_pkg::SAMPLE_WIDTH-1:0]      req_sample,
   input  logic [trs_pkg::POS_WIDTH-1:0]         req_position,
   // segment beats
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [trs_pkg::SEG_WIDTH-1:0]         rsp_seg_begin,
   output logic [trs_pkg::SEG_WIDTH-1:0]         rsp_seg_end,
   output logic [trs_pkg::AVG_WIDTH-1:0]         rsp_seg_average,
   output logic [trs_pkg::NUM_WIDTH-1:0]         rsp_seg_number,
   // register writes
   input  logic                                  csr_we,
   input  logic [trs_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [trs_pkg::CSR_WIDTH-1:0]         csr_wdata
);

   // configuration registers
   trs_pkg::smp_type     threshold_ff;
   trs_pkg::min_type     min_size_ff;
   trs_pkg::guard_type   begin_guard_ff;
   trs_pkg::guard_type   end_pad_ff;
   trs_pkg::total_type   total_size_ff;

   // front to queue to back
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   trs_pkg::seg_job_type q_in_data;
   trs_pkg::seg_job_type q_out_data;

   // register file; indexes beyond the list fall through and are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= '0;
         min_size_ff    <= '0;
         begin_guard_ff <= '0;
         end_pad_ff     <= '0;
         total_size_ff  <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            trs_pkg::REG_THRESHOLD: begin
               // threshold keeps the sample width
               threshold_ff <= trs_pkg::smp_type'(csr_wdata[trs_pkg::THR_IN_WIDTH-1:0]);
            end
            trs_pkg::REG_MIN_SIZE: begin
               min_size_ff <= csr_wdata[trs_pkg::MIN_WIDTH-1:0];
            end
            trs_pkg::REG_BEGIN_GUARD: begin
               begin_guard_ff <= csr_wdata[trs_pkg::GUARD_WIDTH-1:0];
            end
            trs_pkg::REG_END_PAD: begin
               end_pad_ff <= csr_wdata[trs_pkg::GUARD_WIDTH-1:0];
            end
            trs_pkg::REG_TOTAL_SIZE: begin
               total_size_ff <= csr_wdata[trs_pkg::TOTAL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // run tracking and segment qualification
   trs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_op       (req_op),
      .req_sample   (req_sample),
      .req_position (req_position),
      .threshold    (threshold_ff),
      .min_size     (min_size_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_in_data)
   );

   // decouples the front, one sample per cycle while the queue has room, from the slow divider
   trs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   // clamps, average and the result register
   trs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .begin_guard     (begin_guard_ff),
      .end_pad         (end_pad_ff),
      .total_size      (total_size_ff),
      .q_empty         (q_empty),
      .q_data          (q_out_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_seg_begin   (rsp_seg_begin),
      .rsp_seg_end     (rsp_seg_end),
      .rsp_seg_average (rsp_seg_average),
      .rsp_seg_number  (rsp_seg_number)
   );

endmodule
